// File: design/cmpf_pkg.sv
// cmpf_pkg: shared types and constants for the cat map period finder.
// No dependencies; used by cmpf_ctrl, cmpf_dpath and cat_map_period_finder.
package cmpf_pkg;

    localparam int DIM_W    = 7;
    localparam int ELEM_W   = 32;
    localparam int PERIOD_W = 8;

    localparam logic [DIM_W-1:0]    DIM_RESET  = 7'd64;
    localparam logic [PERIOD_W-1:0] PASS_LIMIT = 8'd255;

    typedef struct packed {
        logic load_wr;       // store one input word
        logic search_start;  // clear pass count and buffer select
        logic pass_start;    // reset pass counters and mismatch flag
        logic pass_step;     // issue one permutation read
        logic pass_done;     // bump pass count, swap buffers
        logic out_load;      // capture period into output register
    } t_cmd;

    typedef struct packed {
        logic load_last;     // word being loaded completes the matrix
        logic pass_last;     // current step is the last of the pass
        logic match;         // finished pass equals the original
        logic pass_limit;    // pass count is one below saturation
    } t_status;

endpackage

// File: design/cmpf_dpath.sv
// cmpf_dpath: matrix stores, load/pass counters, permutation and compare.
// Depends on cmpf_pkg; driven by cmpf_ctrl through t_cmd, reports t_status.
module cmpf_dpath #(
    parameter int MAX_DIM = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [cmpf_pkg::DIM_W-1:0]     i_cfg_data,
    input  logic [cmpf_pkg::ELEM_W-1:0]    i_element,
    input  cmpf_pkg::t_cmd                 i_cmd,
    output cmpf_pkg::t_status              o_st,
    output logic [cmpf_pkg::PERIOD_W-1:0]  o_period
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int SIDE_W = $clog2(MAX_DIM + 1);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TOT_W  = 2 * SIDE_W;
    localparam int RESET_SIDE = (int'(cmpf_pkg::DIM_RESET) > MAX_DIM) ?
                                MAX_DIM : int'(cmpf_pkg::DIM_RESET);

    function automatic logic [SIDE_W-1:0] inc_mod(input logic [SIDE_W-1:0] x,
                                                  input logic [SIDE_W-1:0] m);
        logic [SIDE_W:0] t;
        t = {1'b0, x} + 1'b1;
        if (t >= {1'b0, m}) t = t - {1'b0, m};
        return t[SIDE_W-1:0];
    endfunction

    function automatic logic [SIDE_W-1:0] add2_mod(input logic [SIDE_W-1:0] x,
                                                   input logic [SIDE_W-1:0] m);
        logic [SIDE_W:0] t;
        t = {1'b0, x} + 2'd2;
        if (t >= {1'b0, m}) t = t - {1'b0, m};
        if (t >= {1'b0, m}) t = t - {1'b0, m};
        return t[SIDE_W-1:0];
    endfunction

    logic [cmpf_pkg::ELEM_W-1:0] r_mem_orig [DEPTH];
    logic [cmpf_pkg::ELEM_W-1:0] r_mem_a    [DEPTH];
    logic [cmpf_pkg::ELEM_W-1:0] r_mem_b    [DEPTH];
    logic [cmpf_pkg::ELEM_W-1:0] r_rd_orig, r_rd_a, r_rd_b;

    logic [SIDE_W-1:0]              r_side;
    logic [ADDR_W-1:0]              r_load_cnt;
    logic [SIDE_W-1:0]              r_i, r_j, r_row, r_col, r_row0, r_col0;
    logic [ADDR_W-1:0]              r_src;
    logic                           r_wv;
    logic [ADDR_W-1:0]              r_waddr;
    logic                           r_ping;
    logic                           r_mismatch;
    logic [cmpf_pkg::PERIOD_W-1:0]  r_pass;
    logic [cmpf_pkg::PERIOD_W-1:0]  r_period;

    logic [TOT_W-1:0]               w_total, w_load_next, w_prod, w_dest;
    logic [ADDR_W-1:0]              w_dest_addr;
    logic [cmpf_pkg::ELEM_W-1:0]    w_src_data;
    logic [SIDE_W-1:0]              w_row0_n, w_col0_n;
    logic                           w_row_end;

    assign w_total     = r_side * r_side;
    assign w_load_next = TOT_W'(r_load_cnt) + 1'b1;
    assign w_prod      = r_row * r_side;
    assign w_dest      = w_prod + TOT_W'(r_col);
    assign w_dest_addr = w_dest[ADDR_W-1:0];
    assign w_src_data  = r_ping ? r_rd_b : r_rd_a;
    assign w_row_end   = (r_j == r_side - 1'b1);
    assign w_row0_n    = add2_mod(r_row0, r_side);
    assign w_col0_n    = inc_mod(r_col0, r_side);

    assign o_st.load_last  = (w_load_next >= w_total);
    assign o_st.pass_last  = w_row_end && (r_i == r_side - 1'b1);
    assign o_st.match      = !r_mismatch;
    assign o_st.pass_limit = (r_pass == cmpf_pkg::PASS_LIMIT - 1'b1);
    assign o_period        = r_period;

    // side register, clamped on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= SIDE_W'(RESET_SIDE);
        end else if (i_cfg_valid) begin
            if (i_cfg_data == '0) begin
                r_side <= SIDE_W'(1);
            end else if (int'(i_cfg_data) > MAX_DIM) begin
                r_side <= SIDE_W'(MAX_DIM);
            end else begin
                r_side <= SIDE_W'(i_cfg_data);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_cnt <= '0;
            r_pass     <= '0;
            r_ping     <= 1'b0;
            r_mismatch <= 1'b0;
            r_wv       <= 1'b0;
        end else begin
            if (i_cmd.load_wr) begin
                r_load_cnt <= o_st.load_last ? '0 : w_load_next[ADDR_W-1:0];
            end
            if (i_cmd.search_start) begin
                r_pass <= '0;
                r_ping <= 1'b0;
            end else if (i_cmd.pass_done) begin
                r_pass <= r_pass + 1'b1;
                r_ping <= !r_ping;
            end
            if (i_cmd.pass_start) begin
                r_mismatch <= 1'b0;
            end else if (r_wv && (w_src_data != r_rd_orig)) begin
                r_mismatch <= 1'b1;
            end
            r_wv <= i_cmd.pass_step;
        end
    end

    // pass counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.pass_start) begin
            r_i    <= '0;
            r_j    <= '0;
            r_row  <= '0;
            r_col  <= '0;
            r_row0 <= '0;
            r_col0 <= '0;
            r_src  <= '0;
        end else if (i_cmd.pass_step) begin
            r_src <= r_src + 1'b1;
            if (w_row_end) begin
                r_j    <= '0;
                r_i    <= r_i + 1'b1;
                r_row0 <= w_row0_n;
                r_col0 <= w_col0_n;
                r_row  <= w_row0_n;
                r_col  <= w_col0_n;
            end else begin
                r_j   <= r_j + 1'b1;
                r_row <= inc_mod(r_row, r_side);
                r_col <= inc_mod(r_col, r_side);
            end
        end
        r_waddr <= w_dest_addr;
        if (i_cmd.out_load) begin
            r_period <= r_pass;
        end
    end

    // stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) begin
            r_mem_orig[r_load_cnt] <= i_element;
        end
        r_rd_orig <= r_mem_orig[w_dest_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) begin
            r_mem_a[r_load_cnt] <= i_element;
        end else if (r_wv && r_ping) begin
            r_mem_a[r_waddr] <= w_src_data;
        end
        r_rd_a <= r_mem_a[r_src];
    end

    always_ff @(posedge i_clk) begin
        if (r_wv && !r_ping) begin
            r_mem_b[r_waddr] <= w_src_data;
        end
        r_rd_b <= r_mem_b[r_src];
    end

    a_wr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wv |-> !i_cmd.load_wr)
        else $error("load write collides with pass write");

    a_dest_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pass_step |-> (w_dest < w_total))
        else $error("permuted address out of range");

    a_rc_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pass_step |-> (r_row < r_side) && (r_col < r_side) && (r_i < r_side))
        else $error("row or column index out of range");

endmodule

// File: design/cmpf_ctrl.sv
// cmpf_ctrl: sequencing of load, permutation passes, compare and result output.
// Depends on cmpf_pkg; commands cmpf_dpath via t_cmd and reads t_status.
module cmpf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_valid,
    output logic              o_s_ready,
    output logic              o_m_valid,
    input  logic              i_m_ready,
    input  cmpf_pkg::t_status i_st,
    output cmpf_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_PASS  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_m_valid, n_m_valid;
    logic       w_accept;

    assign o_s_ready = (r_state == S_LOAD);
    assign o_m_valid = r_m_valid;
    assign w_accept  = i_s_valid && o_s_ready;

    always_comb begin
        n_state   = r_state;
        n_m_valid = r_m_valid && !i_m_ready;
        o_cmd     = '0;
        case (r_state)
            S_LOAD: begin
                if (w_accept) begin
                    o_cmd.load_wr = 1'b1;
                    if (i_st.load_last) begin
                        o_cmd.search_start = 1'b1;
                        o_cmd.pass_start   = 1'b1;
                        n_state            = S_PASS;
                    end
                end
            end
            S_PASS: begin
                o_cmd.pass_step = 1'b1;
                if (i_st.pass_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.pass_done = 1'b1;
                if (i_st.match || i_st.pass_limit) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.pass_start = 1'b1;
                    n_state          = S_PASS;
                end
            end
            S_OUT: begin
                if (!r_m_valid || i_m_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_m_valid      = 1'b1;
                    n_state        = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_m_valid || i_m_ready))
        else $error("result overwritten before taken");

    a_drain_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |=> o_cmd.pass_done)
        else $error("pass not closed after drain");

endmodule

// File: design/cat_map_period_finder.sv
// cat_map_period_finder: top level, Arnold cat map period of a loaded matrix.
// Depends on cmpf_pkg, cmpf_ctrl and cmpf_dpath.
//
// Usage:
//   cfg channel: i_cfg_valid/o_cfg_ready/i_cfg_data sets the side dim (0 acts
//   as 1, values above MAX_DIM act as MAX_DIM). Write only while idle.
//   s_axis: one 32-bit element per word, row-major. tready is high while
//   loading; the word completing dim*dim elements starts the search.
//   m_axis: one 8-bit word per matrix, the number of passes until the
//   permuted matrix equals the original, saturating at 255.
// Flow: each pass walks all dim*dim positions through one read port of the
//   working buffer. s_axis tready stays low during the search.
// Reset: sides returns to 64 (clamped), load position to zero, no result held.
// Stall: the result sits in an output register; loading of the next matrix
//   goes on while it waits. A finished search holds until the register frees.
module cat_map_period_finder #(
    parameter int MAX_DIM = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cmpf_pkg::DIM_W-1:0]      i_cfg_data,       // dim
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [cmpf_pkg::ELEM_W-1:0]     i_s_axis_tdata,   // [31:0] element
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [cmpf_pkg::PERIOD_W-1:0]   o_m_axis_tdata    // [7:0] period
);

    cmpf_pkg::t_cmd    w_cmd;
    cmpf_pkg::t_status w_st;

    assign o_cfg_ready = 1'b1;

    cmpf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .i_st      (w_st),
        .o_cmd     (w_cmd)
    );

    cmpf_dpath #(
        .MAX_DIM (MAX_DIM)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_element   (i_s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_st        (w_st),
        .o_period    (o_m_axis_tdata)
    );

endmodule
